// File: rtl/pdn_pkg.sv
// Shared types and constants for the pose denormalize pipeline.
package pdn_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;
  localparam logic [23:0] SCALE_RESET = 24'd65536;
  localparam logic [16:0] ONE_Q = 17'd65536;

  typedef struct packed {
    logic signed [56:0] px;
    logic signed [56:0] py;
    logic [63:0] c2;
    logic [63:0] s2;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic sat;
    logic c_neg;
    logic s_neg;
    logic [31:0] cm;
    logic [31:0] sm;
    logic [63:0] v;
    logic [63:0] res;
    logic [31:0] n;
    logic [47:0] nc;
    logic [47:0] ns;
    logic [31:0] rc;
    logic [31:0] rs;
    logic [16:0] qc;
    logic [16:0] qs;
    logic signed [17:0] co;
    logic signed [17:0] so;
  } item_t;

endpackage

// File: rtl/pdn_front.sv
// Front stages: position scaling with rounding and saturation, heading squares.
module pdn_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [23:0]   scale,
  input  logic          i_valid,
  output logic          i_ready,
  input  logic [127:0]  i_data,
  output logic          o_valid,
  input  logic          o_ready,
  output pdn_pkg::item_t o_item
);
  localparam int N = 2;

  logic [N-1:0]   vld_r;
  pdn_pkg::item_t st_r [N];
  pdn_pkg::item_t st_nxt [N];
  logic [N:0]     rdy;

  logic signed [31:0] xi, yi, ci, si;
  logic signed [56:0] qx, qy;
  logic signed [40:0] rx, ry;
  logic               satx, saty;

  assign xi = i_data[31:0];
  assign yi = i_data[63:32];
  assign ci = i_data[95:64];
  assign si = i_data[127:96];

  always_comb begin
    st_nxt[0] = '0;
    st_nxt[0].px = 57'(xi * $signed({1'b0, scale}));
    st_nxt[0].py = 57'(yi * $signed({1'b0, scale}));
    st_nxt[0].c_neg = ci[31];
    st_nxt[0].s_neg = si[31];
    st_nxt[0].cm = ci[31] ? 32'(-ci) : 32'(ci);
    st_nxt[0].sm = si[31] ? 32'(-si) : 32'(si);
    st_nxt[0].c2 = 64'(st_nxt[0].cm) * 64'(st_nxt[0].cm);
    st_nxt[0].s2 = 64'(st_nxt[0].sm) * 64'(st_nxt[0].sm);

    st_nxt[1] = st_r[0];
    qx = st_r[0].px + 57'sd32768;
    qy = st_r[0].py + 57'sd32768;
    rx = qx[56:16];
    ry = qy[56:16];
    satx = !((&rx[40:31]) || !(|rx[40:31]));
    saty = !((&ry[40:31]) || !(|ry[40:31]));
    st_nxt[1].x = satx ? (rx[40] ? 32'sh80000000 : 32'sh7fffffff) : rx[31:0];
    st_nxt[1].y = saty ? (ry[40] ? 32'sh80000000 : 32'sh7fffffff) : ry[31:0];
    st_nxt[1].sat = satx | saty;
    st_nxt[1].v = st_r[0].c2 + st_r[0].s2;
  end

  assign rdy[N] = o_ready;
  for (genvar i = 0; i < N; i++) begin : g_rdy
    assign rdy[i] = !vld_r[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= (i == 0) ? i_valid : vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (rdy[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign i_ready = rdy[0];
  assign o_valid = vld_r[N-1];
  assign o_item  = st_r[N-1];
endmodule

// File: rtl/pdn_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module pdn_isqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           i_valid,
  output logic           i_ready,
  input  pdn_pkg::item_t i_item,
  output logic           o_valid,
  input  logic           o_ready,
  output pdn_pkg::item_t o_item
);
  localparam int N = pdn_pkg::SQRT_STEPS;

  logic [N-1:0]   vld_r;
  pdn_pkg::item_t st_r [N];
  pdn_pkg::item_t st_nxt [N];
  logic [N:0]     rdy;

  always_comb begin
    pdn_pkg::item_t p;
    logic [63:0] bitv;
    logic [63:0] t;
    for (int k = 0; k < N; k++) begin
      p = (k == 0) ? i_item : st_r[k-1];
      if (k == 0) begin
        p.res = '0;
      end
      bitv = 64'(1) << (62 - 2 * k);
      t = p.res + bitv;
      st_nxt[k] = p;
      if (p.v >= t) begin
        st_nxt[k].v = p.v - t;
        st_nxt[k].res = (p.res >> 1) + bitv;
      end else begin
        st_nxt[k].res = p.res >> 1;
      end
    end
  end

  assign rdy[N] = o_ready;
  for (genvar i = 0; i < N; i++) begin : g_rdy
    assign rdy[i] = !vld_r[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= (i == 0) ? i_valid : vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (rdy[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign i_ready = rdy[0];
  assign o_valid = vld_r[N-1];
  assign o_item  = st_r[N-1];
endmodule

// File: rtl/pdn_div.sv
// Pipelined restoring dividers for the unit heading pair, with clamp and sign.
module pdn_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           i_valid,
  output logic           i_ready,
  input  pdn_pkg::item_t i_item,
  output logic           o_valid,
  input  logic           o_ready,
  output pdn_pkg::item_t o_item
);
  localparam int D = pdn_pkg::DIV_STEPS;
  localparam int N = D + 2;

  logic [N-1:0]   vld_r;
  pdn_pkg::item_t st_r [N];
  pdn_pkg::item_t st_nxt [N];
  logic [N:0]     rdy;

  always_comb begin
    pdn_pkg::item_t p;
    logic [31:0] nn;
    logic [32:0] tc, ts;
    logic [16:0] mc, ms;
    // prep: norm floor, numerators, initial remainders
    p = i_item;
    nn = (p.res[31:0] == 32'd0) ? 32'd1 : p.res[31:0];
    st_nxt[0] = p;
    st_nxt[0].n = nn;
    st_nxt[0].nc = {p.cm, 16'd0} + 48'(nn >> 1);
    st_nxt[0].ns = {p.sm, 16'd0} + 48'(nn >> 1);
    st_nxt[0].rc = 32'(st_nxt[0].nc[47:16+1]);
    st_nxt[0].rs = 32'(st_nxt[0].ns[47:16+1]);
    st_nxt[0].qc = '0;
    st_nxt[0].qs = '0;
    for (int k = 1; k <= D; k++) begin
      p = st_r[k-1];
      st_nxt[k] = p;
      tc = {p.rc, p.nc[D-k]};
      ts = {p.rs, p.ns[D-k]};
      if (tc >= {1'b0, p.n}) begin
        tc = tc - {1'b0, p.n};
        st_nxt[k].qc = {p.qc[15:0], 1'b1};
      end else begin
        st_nxt[k].qc = {p.qc[15:0], 1'b0};
      end
      if (ts >= {1'b0, p.n}) begin
        ts = ts - {1'b0, p.n};
        st_nxt[k].qs = {p.qs[15:0], 1'b1};
      end else begin
        st_nxt[k].qs = {p.qs[15:0], 1'b0};
      end
      st_nxt[k].rc = tc[31:0];
      st_nxt[k].rs = ts[31:0];
    end
    p = st_r[D];
    mc = (p.qc > pdn_pkg::ONE_Q) ? pdn_pkg::ONE_Q : p.qc;
    ms = (p.qs > pdn_pkg::ONE_Q) ? pdn_pkg::ONE_Q : p.qs;
    st_nxt[D+1] = p;
    st_nxt[D+1].co = p.c_neg ? -$signed({1'b0, mc}) : $signed({1'b0, mc});
    st_nxt[D+1].so = p.s_neg ? -$signed({1'b0, ms}) : $signed({1'b0, ms});
  end

  assign rdy[N] = o_ready;
  for (genvar i = 0; i < N; i++) begin : g_rdy
    assign rdy[i] = !vld_r[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= (i == 0) ? i_valid : vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (rdy[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign i_ready = rdy[0];
  assign o_valid = vld_r[N-1];
  assign o_item  = st_r[N-1];
endmodule

// File: rtl/pose_denormalize_core.sv
// Pose denormalize top level: position scaling and heading unit normalization.
// Takes one pose per cycle unless the output stalls; each passes in order through
// 2 front stages, 32 square root stages, 1 prep, 17 divide stages and 1 clamp stage.
// Every stage holds its own item, so a stall at the output backs up stage by stage
// and the block keeps taking items until the pipeline is full. The user must write
// the position scale register via the cfg port only while idle; not enforced here.
module pose_denormalize_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // pos_x_in, pos_y_in, cos_in, sin_in
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // pos_x_out, pos_y_out, cos_out, sin_out, zero pad
  output logic         out_tuser   // saturated
);
  logic [23:0]    scale_r;
  logic           f_valid, f_ready, q_valid, q_ready;
  pdn_pkg::item_t f_item, q_item, d_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= pdn_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      scale_r <= cfg_data;
    end
  end

  pdn_front u_front (
    .clk(clk), .rst_n(rst_n), .scale(scale_r),
    .i_valid(in_tvalid), .i_ready(in_tready), .i_data(in_tdata),
    .o_valid(f_valid), .o_ready(f_ready), .o_item(f_item)
  );

  pdn_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n),
    .i_valid(f_valid), .i_ready(f_ready), .i_item(f_item),
    .o_valid(q_valid), .o_ready(q_ready), .o_item(q_item)
  );

  pdn_div u_div (
    .clk(clk), .rst_n(rst_n),
    .i_valid(q_valid), .i_ready(q_ready), .i_item(q_item),
    .o_valid(out_tvalid), .o_ready(out_tready), .o_item(d_item)
  );

  assign out_tdata = {4'd0, d_item.so, d_item.co, d_item.y, d_item.x};
  assign out_tuser = d_item.sat;

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      d_item.x == 32'sh7fffffff || d_item.x == 32'sh80000000 ||
      d_item.y == 32'sh7fffffff || d_item.y == 32'sh80000000)
    else $error("saturated flag without clipped position");

  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> d_item.co <= 18'sd65536 && d_item.co >= -18'sd65536)
    else $error("cos out of unit range");

  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> d_item.so <= 18'sd65536 && d_item.so >= -18'sd65536)
    else $error("sin out of unit range");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output stage empty");
endmodule

// File: tb/pose_denormalize_core_tb.sv
// Self-checking testbench for pose_denormalize_core: pose scaling and heading normalization.
module pose_denormalize_core_tb;

  localparam int LATENCY = 53;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [17:0] co;
    logic signed [17:0] so;
    logic sat;
  } pose_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [23:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [127:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [103:0] out_tdata;
  logic out_tuser;

  logic [23:0] scale_q;
  pose_t pending_poses[$];
  int errors;
  int idle_cycles;
  bit out_stall_en;
  bit hold_off_req;

  pose_denormalize_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [31:0] scale_pos(input logic signed [31:0] p,
                                                   inout logic clip);
    logic signed [63:0] q;
    logic signed [63:0] r;
    q = 64'(p) * $signed({40'd0, scale_q}) + 64'sd32768;
    r = q >>> 16;
    if (r > 64'sd2147483647) begin
      clip = 1;
      r = 64'sd2147483647;
    end else if (r < -64'sd2147483648) begin
      clip = 1;
      r = -64'sd2147483648;
    end
    return r[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [17:0] unit_part(input logic signed [31:0] c,
                                                   input logic [63:0] n);
    logic [63:0] mag;
    logic [63:0] q;
    mag = c[31] ? 64'(-64'(c)) : 64'(c);
    q = (mag * 64'd65536 + n / 2) / n;
    if (q > 64'd65536) q = 64'd65536;
    return c[31] ? -$signed(q[17:0]) : $signed(q[17:0]);
  endfunction

  function automatic pose_t predict_pose(input logic [127:0] d);
    pose_t r;
    logic clip;
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic [63:0] cm;
    logic [63:0] sm;
    logic [63:0] n;
    clip = 0;
    r.px = scale_pos(d[31:0], clip);
    r.py = scale_pos(d[63:32], clip);
    c = d[95:64];
    s = d[127:96];
    cm = c[31] ? 64'(-64'(c)) : 64'(c);
    sm = s[31] ? 64'(-64'(s)) : 64'(s);
    n = int_sqrt(cm * cm + sm * sm);
    if (n < 1) n = 1;
    r.co = unit_part(c, n);
    r.so = unit_part(s, n);
    r.sat = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        e = pending_poses.pop_front();
        if (out_tdata[31:0] !== e.px) begin
          $display("%0t: pos_x exp %h got %h", $time, e.px, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== e.py) begin
          $display("%0t: pos_y exp %h got %h", $time, e.py, out_tdata[63:32]);
          errors++;
        end
        if (out_tdata[81:64] !== e.co) begin
          $display("%0t: cos exp %h got %h", $time, e.co, out_tdata[81:64]);
          errors++;
        end
        if (out_tdata[99:82] !== e.so) begin
          $display("%0t: sin exp %h got %h", $time, e.so, out_tdata[99:82]);
          errors++;
        end
        if (out_tuser !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $time, e.sat, out_tuser);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int n;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        hold_off_req = 0;
      end
      if (out_stall_en && $urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_tready <= 0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_pose(input logic [127:0] d, input bit gaps);
    int n;
    if (gaps && $urandom_range(0, 4) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    pending_poses = {pending_poses, predict_pose(d)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_scale(input logic [23:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    scale_q = v;
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return {{16{1'b0}}, 16'($urandom())} ^ {32{$urandom_range(0, 1) == 1}};
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] pts[10];
    pts = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0123_4567, 32'hFEDC_BA98};
    for (int i = 0; i < 10; i++)
      send_pose({pts[(i + 3) % 10], pts[(i + 7) % 10], pts[(i + 1) % 10], pts[i]}, 0);
    send_pose({32'h0, 32'h0, 32'h0, 32'h0}, 0);
    send_pose({32'h0, 32'h1, 32'h0, 32'h0}, 0);
    send_pose({32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 0);
    send_pose({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF}, 0);
    send_pose({32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0);
    send_pose({32'h0, 32'h3, 32'h0, 32'h4}, 0);
    drain_results();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_pose({rand_field(), rand_field(), rand_field(), rand_field()}, 1);
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_off_req = 1;
    for (int i = 0; i < 120; i++)
      send_pose({rand_field(), rand_field(), rand_field(), rand_field()}, 0);
    drain_results();
  endtask

  initial begin
    logic [23:0] scales[5];
    scales = '{24'hFF_FFFF, 24'h0, 24'h1, 24'h02_0000, 24'h00_8000};
    errors = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = 0;
    in_tvalid = 0;
    in_tdata = 0;
    out_stall_en = 0;
    hold_off_req = 0;
    scale_q = pdn_pkg::SCALE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    out_stall_en = 1;
    test_random(400);
    foreach (scales[i]) begin
      write_scale(scales[i]);
      test_directed();
      test_random(200);
    end
    write_scale(24'($urandom()));
    test_backpressure();
    test_random(200);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
